@@ rtl/core/sltx_pkg.sv @@
// Shared constants, types and hex decode for the SLCAN transmit line parser.
package sltx_pkg;

    localparam int unsigned MAX_DATA_BYTES_DEF = 8;
    localparam int unsigned DATA_W             = 64;
    localparam int unsigned ID_W               = 12;
    localparam int unsigned LEN_W              = 4;
    localparam int unsigned POS_W              = 5;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TX    = 8'h74;
    localparam logic [7:0] CH_CLOSE = 8'h43;

    localparam int unsigned POS_LEN  = 4;
    localparam int unsigned POS_DATA = 5;
    localparam int unsigned POS_MAX  = 31;

    localparam logic LC_TRANSMIT = 1'b0;
    localparam logic LC_CLOSE    = 1'b1;

    typedef struct packed {
        logic [7:0]        cmd_char;
        logic              started;
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
    } line_state_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'h0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c[3:0];
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = 4'(c[3:0] + 4'd9);
        end
        return v;
    endfunction

endpackage

@@ rtl/core/sltx_line_accum.sv @@
// Per-line state: command character, position counter and digit accumulators.
module sltx_line_accum #(
    parameter int unsigned MAX_DATA_BYTES = sltx_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  logic [7:0]            rx_byte,
    output sltx_pkg::line_state_t state
);

    localparam int unsigned ACC_W = 8 * MAX_DATA_BYTES;

    logic [7:0]                    cmd_reg, cmd_next;
    logic [sltx_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [sltx_pkg::ID_W-1:0]     id_reg, id_next;
    logic [sltx_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [ACC_W-1:0]              data_reg, data_next;
    logic [3:0]                    nib;

    assign nib = sltx_pkg::hex_value(rx_byte);

    always_comb
    begin
        cmd_next  = cmd_reg;
        pos_next  = pos_reg;
        id_next   = id_reg;
        len_next  = len_reg;
        data_next = data_reg;
        if (take)
        begin
            if (rx_byte == sltx_pkg::CH_CR)
            begin
                cmd_next  = 8'h00;
                pos_next  = '0;
                id_next   = '0;
                len_next  = '0;
                data_next = '0;
            end
            else
            begin
                if (pos_reg == '0)
                begin
                    cmd_next = rx_byte;
                end
                else if (cmd_reg == sltx_pkg::CH_TX)
                begin
                    if (pos_reg < sltx_pkg::POS_W'(sltx_pkg::POS_LEN))
                    begin
                        id_next = {id_reg[sltx_pkg::ID_W-5:0], nib};
                    end
                    else if (pos_reg == sltx_pkg::POS_W'(sltx_pkg::POS_LEN))
                    begin
                        len_next = nib;
                    end
                    else
                    begin
                        for (int b = 0; b < int'(MAX_DATA_BYTES); b++)
                        begin
                            // high digit of each byte arrives first
                            if (pos_reg == sltx_pkg::POS_W'(sltx_pkg::POS_DATA + 2 * b))
                            begin
                                data_next[8*b+4 +: 4] = data_reg[8*b+4 +: 4] | nib;
                            end
                            if (pos_reg == sltx_pkg::POS_W'(sltx_pkg::POS_DATA + 2 * b + 1))
                            begin
                                data_next[8*b +: 4] = data_reg[8*b +: 4] | nib;
                            end
                        end
                    end
                end
                if (pos_reg != sltx_pkg::POS_W'(sltx_pkg::POS_MAX))
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg  <= 8'h00;
            pos_reg  <= '0;
            id_reg   <= '0;
            len_reg  <= '0;
            data_reg <= '0;
        end
        else
        begin
            cmd_reg  <= cmd_next;
            pos_reg  <= pos_next;
            id_reg   <= id_next;
            len_reg  <= len_next;
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        state.cmd_char = cmd_reg;
        state.started  = (pos_reg != '0);
        state.id       = id_reg;
        state.len      = len_reg;
        state.data     = sltx_pkg::DATA_W'(data_reg);
    end

endmodule

@@ rtl/core/sltx_frame_build.sv @@
// Result formation at the line terminator and the output register.
module sltx_frame_build #(
    parameter int unsigned MAX_DATA_BYTES = sltx_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          line_end,
    input  sltx_pkg::line_state_t         state,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic                          line_command,
    output logic                          frame_valid,
    output logic [sltx_pkg::ID_W-1:0]     frame_id,
    output logic [sltx_pkg::LEN_W-1:0]    frame_length,
    output logic [sltx_pkg::DATA_W-1:0]   frame_data
);

    logic                          is_tx, is_close, load, ok;
    logic                          valid_reg, valid_next;
    logic                          cmd_reg, cmd_next;
    logic                          ok_reg, ok_next;
    logic [sltx_pkg::ID_W-1:0]     id_reg, id_next;
    logic [sltx_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [sltx_pkg::DATA_W-1:0]   data_reg, data_next;

    assign is_tx    = state.started && (state.cmd_char == sltx_pkg::CH_TX);
    assign is_close = state.started && (state.cmd_char == sltx_pkg::CH_CLOSE);
    assign load     = line_end && (is_tx || is_close);
    assign ok       = (state.id != '0) && (state.len != '0)
                      && (state.len <= sltx_pkg::LEN_W'(MAX_DATA_BYTES));

    always_comb
    begin
        cmd_next  = is_tx ? sltx_pkg::LC_TRANSMIT : sltx_pkg::LC_CLOSE;
        ok_next   = is_tx && ok;
        id_next   = is_tx ? state.id : '0;
        len_next  = is_tx ? state.len : '0;
        data_next = '0;
        for (int b = 0; b < int'(MAX_DATA_BYTES); b++)
        begin
            if (ok_next && (sltx_pkg::LEN_W'(b) < state.len))
            begin
                data_next[8*b +: 8] = state.data[8*b +: 8];
            end
        end
        valid_next = load ? 1'b1 : (valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg  <= cmd_next;
            ok_reg   <= ok_next;
            id_reg   <= id_next;
            len_reg  <= len_next;
            data_reg <= data_next;
        end
    end

    assign out_valid    = valid_reg;
    assign line_command = cmd_reg;
    assign frame_valid  = ok_reg;
    assign frame_id     = id_reg;
    assign frame_length = len_reg;
    assign frame_data   = data_reg;

endmodule

@@ rtl/core/slcan_transmit_line_parser_top.sv @@
// Top level of the SLCAN transmit line parser.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------------------
//  input    | in        | in_valid / in_stall  | rx_byte
//  result   | out       | out_valid / out_stall| line_command, frame_valid, frame_id,
//           |           |                      | frame_length, frame_data
//
// One character per cycle unless stalled; a result is registered on its terminator.
// The line state registers and the output register are the only pipeline stages.
// in_stall rises only while a result is held and out_stall is high.
// Asynchronous reset returns to start of line with the output register empty.
module slcan_transmit_line_parser_top #(
    parameter int unsigned MAX_DATA_BYTES = sltx_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    rx_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          line_command,
    output logic                          frame_valid,
    output logic [sltx_pkg::ID_W-1:0]     frame_id,
    output logic [sltx_pkg::LEN_W-1:0]    frame_length,
    output logic [sltx_pkg::DATA_W-1:0]   frame_data
);

    logic                  take;
    sltx_pkg::line_state_t state;

    assign in_stall = out_valid && out_stall;
    assign take     = in_valid && !in_stall;

    sltx_line_accum #(
        .MAX_DATA_BYTES(MAX_DATA_BYTES)
    ) u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (rx_byte),
        .state   (state)
    );

    sltx_frame_build #(
        .MAX_DATA_BYTES(MAX_DATA_BYTES)
    ) u_build (
        .clk          (clk),
        .rst_n        (rst_n),
        .line_end     (take && (rx_byte == sltx_pkg::CH_CR)),
        .state        (state),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .line_command (line_command),
        .frame_valid  (frame_valid),
        .frame_id     (frame_id),
        .frame_length (frame_length),
        .frame_data   (frame_data)
    );

endmodule

@@ rtl/core/sltx_checker.sv @@
// Port-level checks for the SLCAN transmit line parser, bound to the top level.
module sltx_checker #(
    parameter int unsigned MAX_DATA_BYTES = sltx_pkg::MAX_DATA_BYTES_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          line_command,
    input logic                          frame_valid,
    input logic [sltx_pkg::ID_W-1:0]     frame_id,
    input logic [sltx_pkg::LEN_W-1:0]    frame_length,
    input logic [sltx_pkg::DATA_W-1:0]   frame_data
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_data) && $stable(frame_id))
        else $error("stalled result changed");

    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held result");

    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (line_command == sltx_pkg::LC_CLOSE)
            |-> !frame_valid && frame_id == '0 && frame_length == '0 && frame_data == '0)
        else $error("close acknowledge carries frame content");

    a_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_valid |-> frame_data == '0)
        else $error("data on an invalid frame");

    a_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_valid |-> frame_id != '0 && frame_length != '0
            && frame_length <= sltx_pkg::LEN_W'(MAX_DATA_BYTES))
        else $error("frame marked valid out of range");

endmodule

bind slcan_transmit_line_parser_top sltx_checker #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
) u_sltx_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .line_command (line_command),
    .frame_valid  (frame_valid),
    .frame_id     (frame_id),
    .frame_length (frame_length),
    .frame_data   (frame_data)
);
